@@ design/jts_pkg.sv @@
package jts_pkg;

    // Scanner position between, or inside, tokens.
    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_STR  = 2'd1,
        MODE_NUM  = 2'd2,
        MODE_KW   = 2'd3
    } mode_t;

    // Token kinds as they appear on the result channel.
    typedef enum logic [3:0] {
        KIND_STRING   = 4'd0,
        KIND_NUMBER   = 4'd1,
        KIND_TRUE     = 4'd2,
        KIND_FALSE    = 4'd3,
        KIND_NULL     = 4'd4,
        KIND_LBRACE   = 4'd5,
        KIND_RBRACE   = 4'd6,
        KIND_LBRACKET = 4'd7,
        KIND_RBRACKET = 4'd8,
        KIND_COMMA    = 4'd9,
        KIND_COLON    = 4'd10,
        KIND_ERROR    = 4'd11,
        KIND_END      = 4'd12
    } kind_t;

    // Keyword identifiers held while a keyword is being matched.
    localparam logic [1:0] KW_TRUE  = 2'd0;
    localparam logic [1:0] KW_FALSE = 2'd1;
    localparam logic [1:0] KW_NULL  = 2'd2;

    // Character codes.
    localparam logic [7:0] CH_MINUS    = 8'h2D;
    localparam logic [7:0] CH_0        = 8'h30;
    localparam logic [7:0] CH_9        = 8'h39;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LOWER_T  = 8'h74;
    localparam logic [7:0] CH_LOWER_F  = 8'h66;
    localparam logic [7:0] CH_LOWER_N  = 8'h6E;
    localparam logic [7:0] CH_LOWER_R  = 8'h72;
    localparam logic [7:0] CH_LOWER_U  = 8'h75;
    localparam logic [7:0] CH_LOWER_E  = 8'h65;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_L  = 8'h6C;
    localparam logic [7:0] CH_LOWER_S  = 8'h73;

    // One result item.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] value_byte;
        logic       carries_byte;
        logic       token_done;
        logic       last_of_step;
    } result_t;

    // Everything one input byte produces: up to two results.
    typedef struct packed {
        result_t    res0;
        result_t    res1;
        logic [1:0] count;
    } lex_out_t;

endpackage

@@ design/json_token_scanner.sv @@
// A result is registered and appears on the master side in the cycle after its byte's transfer.
// Throughput: one byte per cycle while m_tready is high; a byte with two results (string or keyword cut off by end
// of input, number closed by ',', '}', ']' or end of input) holds s_tready low while the
// second result drains from the two-entry result buffer.
// Reset: synchronous, active low; the scanner returns to idle between tokens and the
// result buffer empties.
module json_token_scanner
    import jts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] value_byte, [8] last_of_step, [15:9] zero
    output logic [4:0]  m_tuser,   // [3:0] token_kind, [4] carries_byte
    output logic        m_tlast    // token_done
);

    lex_out_t lex_out;
    logic     in_fire;
    logic     out_fire;

    logic     out0_valid_reg, out0_valid_next;
    logic     out1_valid_reg, out1_valid_next;
    result_t  out0_reg, out0_next;
    result_t  out1_reg, out1_next;

    // A byte is taken only when both result slots can absorb what it makes.
    assign s_tready = !out1_valid_reg && (!out0_valid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    jts_lexer u_lexer (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (in_fire),
        .in_byte      (s_tdata),
        .end_of_input (s_tlast),
        .lex_out      (lex_out)
    );

    // Result buffer update.
    always_comb begin
        out0_valid_next = out0_valid_reg;
        out1_valid_next = out1_valid_reg;
        out0_next       = out0_reg;
        out1_next       = out1_reg;
        priority if (in_fire) begin
            out0_valid_next = (lex_out.count != 2'd0);
            out1_valid_next = (lex_out.count == 2'd2);
            out0_next       = lex_out.res0;
            out1_next       = lex_out.res1;
        end else if (out_fire) begin
            out0_valid_next = out1_valid_reg;
            out1_valid_next = 1'b0;
            out0_next       = out1_reg;
        end else begin
            out0_valid_next = out0_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out0_valid_reg <= 1'b0;
            out1_valid_reg <= 1'b0;
        end else begin
            out0_valid_reg <= out0_valid_next;
            out1_valid_reg <= out1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out0_reg <= out0_next;
        out1_reg <= out1_next;
    end

    // Master-side packing.
    assign m_tvalid = out0_valid_reg;
    assign m_tdata  = {7'b0000000, out0_reg.last_of_step, out0_reg.value_byte};
    assign m_tuser  = {out0_reg.carries_byte, 4'(out0_reg.kind)};
    assign m_tlast  = out0_reg.token_done;

    // The second slot is only ever filled behind a filled first slot.
    a_slot_order: assert property (@(posedge aclk) disable iff (!aresetn)
        out1_valid_reg |-> out0_valid_reg)
        else $error("second result slot valid while first slot empty");

    // A two-result byte shows its first result without the end-of-step mark.
    a_two_results: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && (lex_out.count == 2'd2)) |=>
            (m_tvalid && out1_valid_reg && !m_tdata[8]))
        else $error("two-result byte not buffered as two transfers");

    // The buffered second result always closes its step.
    a_second_last: assert property (@(posedge aclk) disable iff (!aresetn)
        out1_valid_reg |-> out1_reg.last_of_step)
        else $error("second result of a byte lacks the end-of-step mark");

endmodule

@@ design/jts_lexer.sv @@
module jts_lexer
    import jts_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [7:0] in_byte,
    input  logic       end_of_input,
    output lex_out_t   lex_out
);

    mode_t      mode_reg, mode_next;
    logic [1:0] kw_id_reg, kw_id_next;
    logic [2:0] kw_pos_reg, kw_pos_next;

    // Idle-state lexing of the current byte, shared by the idle and number modes.
    logic       idle_emit;
    kind_t      idle_kind;
    logic       idle_carries;
    logic       idle_done;

    logic       is_space;
    logic       is_num_start;
    logic       num_delim;
    logic [2:0] kw_len_cur;
    logic [7:0] kw_char_cur;
    logic       kw_match;
    logic [2:0] kw_pos_inc;

    function automatic result_t make_result(kind_t kind, logic [7:0] value,
                                            logic carries, logic done, logic last);
        result_t r;
        r.kind         = kind;
        r.value_byte   = value;
        r.carries_byte = carries;
        r.token_done   = done;
        r.last_of_step = last;
        return r;
    endfunction

    function automatic logic [2:0] kw_len(logic [1:0] id);
        logic [2:0] len;
        unique case (id)
            KW_TRUE:  len = 3'd4;
            KW_FALSE: len = 3'd5;
            KW_NULL:  len = 3'd4;
            default:  len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(logic [1:0] id, logic [2:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (id)
            KW_TRUE: begin
                unique case (pos)
                    3'd0:    ch = CH_LOWER_T;
                    3'd1:    ch = CH_LOWER_R;
                    3'd2:    ch = CH_LOWER_U;
                    3'd3:    ch = CH_LOWER_E;
                    default: ch = 8'h00;
                endcase
            end
            KW_FALSE: begin
                unique case (pos)
                    3'd0:    ch = CH_LOWER_F;
                    3'd1:    ch = CH_LOWER_A;
                    3'd2:    ch = CH_LOWER_L;
                    3'd3:    ch = CH_LOWER_S;
                    3'd4:    ch = CH_LOWER_E;
                    default: ch = 8'h00;
                endcase
            end
            KW_NULL: begin
                unique case (pos)
                    3'd0:    ch = CH_LOWER_N;
                    3'd1:    ch = CH_LOWER_U;
                    3'd2:    ch = CH_LOWER_L;
                    3'd3:    ch = CH_LOWER_L;
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Character classes.
    assign is_space     = (in_byte == CH_SPACE) || (in_byte == CH_TAB) ||
                          (in_byte == CH_LF) || (in_byte == CH_CR);
    assign is_num_start = (in_byte == CH_MINUS) ||
                          ((in_byte >= CH_0) && (in_byte <= CH_9));
    assign num_delim    = end_of_input || is_space || (in_byte == CH_COMMA) ||
                          (in_byte == CH_RBRACE) || (in_byte == CH_RBRACKET);

    // Keyword letter compare.
    assign kw_len_cur  = kw_len(kw_id_reg);
    assign kw_char_cur = kw_char(kw_id_reg, kw_pos_reg);
    assign kw_match    = (kw_pos_reg < kw_len_cur) && (in_byte == kw_char_cur);
    assign kw_pos_inc  = kw_pos_reg + 3'd1;

    // Result of lexing the byte from the idle state.
    always_comb begin
        idle_emit    = 1'b1;
        idle_kind    = KIND_ERROR;
        idle_carries = 1'b0;
        idle_done    = 1'b1;
        priority if (end_of_input) begin
            idle_kind = KIND_END;
        end else if (is_space) begin
            idle_emit = 1'b0;
        end else if (in_byte == CH_LBRACE) begin
            idle_kind = KIND_LBRACE;
        end else if (in_byte == CH_RBRACE) begin
            idle_kind = KIND_RBRACE;
        end else if (in_byte == CH_LBRACKET) begin
            idle_kind = KIND_LBRACKET;
        end else if (in_byte == CH_RBRACKET) begin
            idle_kind = KIND_RBRACKET;
        end else if (in_byte == CH_COMMA) begin
            idle_kind = KIND_COMMA;
        end else if (in_byte == CH_COLON) begin
            idle_kind = KIND_COLON;
        end else if ((in_byte == CH_QUOTE) || (in_byte == CH_LOWER_T) ||
                     (in_byte == CH_LOWER_F) || (in_byte == CH_LOWER_N)) begin
            idle_emit = 1'b0;
        end else if (is_num_start) begin
            idle_kind    = KIND_NUMBER;
            idle_carries = 1'b1;
            idle_done    = 1'b0;
        end else begin
            idle_kind = KIND_ERROR;
        end
    end

    // Next state.
    always_comb begin
        mode_next   = mode_reg;
        kw_id_next  = kw_id_reg;
        kw_pos_next = kw_pos_reg;
        unique case (mode_reg)
            MODE_IDLE: begin
                if (!end_of_input) begin
                    priority if (in_byte == CH_QUOTE) begin
                        mode_next = MODE_STR;
                    end else if (in_byte == CH_LOWER_T) begin
                        mode_next   = MODE_KW;
                        kw_id_next  = KW_TRUE;
                        kw_pos_next = 3'd1;
                    end else if (in_byte == CH_LOWER_F) begin
                        mode_next   = MODE_KW;
                        kw_id_next  = KW_FALSE;
                        kw_pos_next = 3'd1;
                    end else if (in_byte == CH_LOWER_N) begin
                        mode_next   = MODE_KW;
                        kw_id_next  = KW_NULL;
                        kw_pos_next = 3'd1;
                    end else if (is_num_start) begin
                        mode_next = MODE_NUM;
                    end else begin
                        mode_next = MODE_IDLE;
                    end
                end
            end
            MODE_STR: begin
                if (end_of_input || (in_byte == CH_QUOTE)) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_NUM: begin
                // A delimiter never opens a new token, so the scanner goes idle.
                if (num_delim) begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_KW: begin
                priority if (end_of_input) begin
                    mode_next = MODE_IDLE;
                end else if (kw_match) begin
                    kw_pos_next = kw_pos_inc;
                    if (kw_pos_inc == kw_len_cur) begin
                        mode_next   = MODE_IDLE;
                        kw_pos_next = 3'd0;
                    end
                end else begin
                    mode_next   = MODE_IDLE;
                    kw_pos_next = 3'd0;
                end
            end
            default: mode_next = MODE_IDLE;
        endcase
    end

    // Results of this byte.
    always_comb begin
        lex_out.res0  = make_result(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b1);
        lex_out.res1  = make_result(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1);
        lex_out.count = 2'd0;
        unique case (mode_reg)
            MODE_IDLE: begin
                lex_out.res0  = make_result(idle_kind,
                                            idle_carries ? in_byte : 8'h00,
                                            idle_carries, idle_done, 1'b1);
                lex_out.count = idle_emit ? 2'd1 : 2'd0;
            end
            MODE_STR: begin
                priority if (end_of_input) begin
                    lex_out.res0  = make_result(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b0);
                    lex_out.res1  = make_result(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1);
                    lex_out.count = 2'd2;
                end else if (in_byte == CH_QUOTE) begin
                    lex_out.res0  = make_result(KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b1);
                    lex_out.count = 2'd1;
                end else begin
                    lex_out.res0  = make_result(KIND_STRING, in_byte, 1'b1, 1'b0, 1'b1);
                    lex_out.count = 2'd1;
                end
            end
            MODE_NUM: begin
                if (num_delim) begin
                    // Close the number, then the delimiter's own token if any.
                    lex_out.res0  = make_result(KIND_NUMBER, 8'h00, 1'b0, 1'b1,
                                                !idle_emit);
                    lex_out.res1  = make_result(idle_kind, 8'h00, 1'b0, 1'b1, 1'b1);
                    lex_out.count = idle_emit ? 2'd2 : 2'd1;
                end else begin
                    lex_out.res0  = make_result(KIND_NUMBER, in_byte, 1'b1, 1'b0, 1'b1);
                    lex_out.count = 2'd1;
                end
            end
            MODE_KW: begin
                priority if (end_of_input) begin
                    lex_out.res0  = make_result(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b0);
                    lex_out.res1  = make_result(KIND_END, 8'h00, 1'b0, 1'b1, 1'b1);
                    lex_out.count = 2'd2;
                end else if (kw_match) begin
                    lex_out.res0  = make_result(kind_t'(4'(KIND_TRUE) + {2'b00, kw_id_reg}),
                                                8'h00, 1'b0, 1'b1, 1'b1);
                    lex_out.count = (kw_pos_inc == kw_len_cur) ? 2'd1 : 2'd0;
                end else begin
                    lex_out.res0  = make_result(KIND_ERROR, 8'h00, 1'b0, 1'b1, 1'b1);
                    lex_out.count = 2'd1;
                end
            end
            default: lex_out.count = 2'd0;
        endcase
    end

    // Scanner state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_IDLE;
            kw_id_reg  <= KW_TRUE;
            kw_pos_reg <= 3'd0;
        end else if (step_en) begin
            mode_reg   <= mode_next;
            kw_id_reg  <= kw_id_next;
            kw_pos_reg <= kw_pos_next;
        end
    end

endmodule
